>>> hdl/permutation_cycle_filter_assert.svh
// assertion macros for the permutation cycle filter
`ifndef PERMUTATION_CYCLE_FILTER_ASSERT_SVH
`define PERMUTATION_CYCLE_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcf assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define PCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcf assertion failed");

`endif

>>> hdl/pcf_pkg.sv
// shared types and constants of the permutation cycle filter
`default_nettype none

package pcf_pkg;

  localparam int MAX_POINTS   = 15;
  localparam int FIELD_POINTS = 15;
  localparam int PNT_W        = 4;
  localparam int IMAGES_W     = FIELD_POINTS * PNT_W;
  localparam int MULT_W       = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int DIGIT_W      = 2;
  localparam int REM_STEPS    = MULT_W / DIGIT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE   = 2'd0,
    REG_PARITY   = 2'd1,
    REG_MULTIPLE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PAR_EVEN = 2'd0,
    PAR_ODD  = 2'd1,
    PAR_ANY  = 2'd2
  } parity_rule_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic done;
    logic cyc_odd;
  } walk_stat_t;

endpackage

`default_nettype wire

>>> hdl/pcf_walk.sv
// cycle walker: visits one point per cycle and records cycle lengths
`default_nettype none

module pcf_walk #(
  parameter int NPTS = pcf_pkg::MAX_POINTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [pcf_pkg::PNT_W-1:0]    degree,
  input  wire logic [pcf_pkg::IMAGES_W-1:0] images,
  output pcf_pkg::walk_stat_t               stat,
  output logic [NPTS-1:0]                   lenmask
);

  localparam int IDX_W = $clog2(NPTS);
  localparam int LEN_W = $clog2(NPTS + 1);

  logic [pcf_pkg::PNT_W-1:0] img [NPTS];
  logic [NPTS-1:0]           visited;
  logic [NPTS-1:0]           visited_next;
  logic [NPTS-1:0]           in_range;
  logic [IDX_W-1:0]          point;
  logic [IDX_W-1:0]          first_free;
  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          len_next;
  logic [pcf_pkg::PNT_W-1:0] nxt;
  logic                      cont;
  logic                      all_seen;
  logic                      running;
  logic                      done;
  logic                      cyc_odd;

  always_comb begin
    visited_next        = visited;
    visited_next[point] = 1'b1;
    len_next            = len + LEN_W'(1);
    nxt                 = img[point];
    cont                = (nxt < degree) && !visited_next[nxt[IDX_W-1:0]];
    all_seen            = &visited_next;
    first_free          = '0;
    for (int i = NPTS - 1; i >= 0; i--) begin
      if (!visited_next[i]) begin
        first_free = IDX_W'(i);
      end
    end
    for (int i = 0; i < NPTS; i++) begin
      in_range[i] = pcf_pkg::PNT_W'(i) < degree;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (go) begin
      running <= degree != '0;
      done    <= degree == '0;
    end else if (running && !cont && all_seen) begin
      running <= 1'b0;
      done    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < NPTS; i++) begin
        img[i] <= images[pcf_pkg::PNT_W*i +: pcf_pkg::PNT_W];
      end
      visited <= ~in_range;
      point   <= '0;
      len     <= '0;
      lenmask <= '0;
      cyc_odd <= degree != '0;
    end else if (running) begin
      visited <= visited_next;
      if (cont) begin
        point <= nxt[IDX_W-1:0];
        len   <= len_next;
      end else begin
        // cycle closed: its length is len + 1
        lenmask[len[IDX_W-1:0]] <= 1'b1;
        len                     <= '0;
        if (!all_seen) begin
          point   <= first_free;
          cyc_odd <= ~cyc_odd;
        end
      end
    end
  end

  assign stat.done    = done;
  assign stat.cyc_odd = cyc_odd;

endmodule

`default_nettype wire

>>> hdl/pcf_rem.sv
// remainder lanes: order multiple modulo every possible cycle length
`default_nettype none

module pcf_rem #(
  parameter int NPTS = pcf_pkg::MAX_POINTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [pcf_pkg::MULT_W-1:0] multiple,
  output logic                            done,
  output logic [NPTS-1:0]                 div_ok
);

  localparam int RW    = $clog2(NPTS + 1);
  localparam int VW    = RW + pcf_pkg::DIGIT_W;
  localparam int CNT_W = $clog2(pcf_pkg::REM_STEPS);

  logic [pcf_pkg::MULT_W-1:0]  sr;
  logic [CNT_W-1:0]            cnt;
  logic                        running;
  logic [pcf_pkg::DIGIT_W-1:0] digit;

  assign digit = sr[pcf_pkg::MULT_W-1 -: pcf_pkg::DIGIT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (go) begin
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running && cnt == CNT_W'(pcf_pkg::REM_STEPS - 1)) begin
      running <= 1'b0;
      done    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sr  <= multiple;
      cnt <= '0;
    end else if (running) begin
      sr  <= sr << pcf_pkg::DIGIT_W;
      cnt <= cnt + CNT_W'(1);
    end
  end

  for (genvar g = 0; g < NPTS; g++) begin : g_lane
    localparam logic [VW-1:0] K = VW'(g + 1);

    logic [RW-1:0] rem;
    logic [VW-1:0] v0;
    logic [VW-1:0] v1;
    logic [VW-1:0] v2;

    // rem < k so v0 < 4k: two conditional subtracts bring it below k
    always_comb begin
      v0 = {rem, digit};
      v1 = (v0 >= (K << 1)) ? v0 - (K << 1) : v0;
      v2 = (v1 >= K) ? v1 - K : v1;
    end

    always_ff @(posedge clk) begin
      if (go) begin
        rem <= '0;
      end else if (running) begin
        rem <= v2[RW-1:0];
      end
    end

    assign div_ok[g] = rem == '0;
  end

endmodule

`default_nettype wire

>>> hdl/permutation_cycle_filter.sv
// result: strobed on done once the remainder lanes and the cycle walk have both finished
// a new transaction is taken only while idle; busy stays high until the result is strobed
// the remainder lanes step through the 32-bit multiple, two bits a cycle,
// and bound the time; the cycle walk visits each point once, at most 15
// reset: degree 15, parity rule any, multiple 0; no transaction in flight
// the receiver cannot stall: done is high for exactly one cycle per result
`default_nettype none

`include "permutation_cycle_filter_assert.svh"

module permutation_cycle_filter #(
  parameter int MAX_POINTS = pcf_pkg::MAX_POINTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [pcf_pkg::IMAGES_W-1:0]   images,
  input  wire logic                           cfg_write,
  input  wire logic [pcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pcf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                done,
  output logic                                odd_parity,
  output logic                                order_ok,
  output logic                                accepted
);

  localparam int NPTS = (MAX_POINTS < pcf_pkg::FIELD_POINTS) ?
                        MAX_POINTS : pcf_pkg::FIELD_POINTS;

  pcf_pkg::state_t            state;
  logic [pcf_pkg::PNT_W-1:0]  degree;
  logic [1:0]                 parity_rule;
  logic [pcf_pkg::MULT_W-1:0] multiple;
  logic [pcf_pkg::PNT_W-1:0]  degree_eff;
  logic                       go;
  logic                       fin;
  pcf_pkg::walk_stat_t        walk_stat;
  logic [NPTS-1:0]            lenmask;
  logic                       rem_done;
  logic [NPTS-1:0]            div_ok;
  logic                       odd_next;
  logic                       order_ok_next;
  logic                       parity_ok;

  assign degree_eff = (degree > pcf_pkg::PNT_W'(NPTS)) ? pcf_pkg::PNT_W'(NPTS) : degree;
  assign busy       = state == pcf_pkg::ST_RUN;
  assign go         = start && state == pcf_pkg::ST_IDLE;
  assign fin        = state == pcf_pkg::ST_RUN && walk_stat.done && rem_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree      <= pcf_pkg::PNT_W'(15);
      parity_rule <= pcf_pkg::PAR_ANY;
      multiple    <= '0;
    end else if (cfg_write) begin
      case (pcf_pkg::cfg_reg_t'(cfg_index))
        pcf_pkg::REG_DEGREE:   degree      <= cfg_data[pcf_pkg::PNT_W-1:0];
        pcf_pkg::REG_PARITY:   parity_rule <= cfg_data[1:0];
        pcf_pkg::REG_MULTIPLE: multiple    <= cfg_data[pcf_pkg::MULT_W-1:0];
        default: ;
      endcase
    end
  end

  pcf_walk #(.NPTS(NPTS)) u_walk (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .degree  (degree_eff),
    .images  (images),
    .stat    (walk_stat),
    .lenmask (lenmask)
  );

  pcf_rem #(.NPTS(NPTS)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .multiple (multiple),
    .done     (rem_done),
    .div_ok   (div_ok)
  );

  always_comb begin
    odd_next      = degree_eff[0] ^ walk_stat.cyc_odd;
    order_ok_next = (multiple == '0) || (&(div_ok | ~lenmask));
    case (parity_rule)
      pcf_pkg::PAR_EVEN: parity_ok = !odd_next;
      pcf_pkg::PAR_ODD:  parity_ok = odd_next;
      default:           parity_ok = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcf_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        pcf_pkg::ST_IDLE: begin
          if (start) begin
            state <= pcf_pkg::ST_RUN;
          end
        end
        pcf_pkg::ST_RUN: begin
          if (fin) begin
            state <= pcf_pkg::ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= pcf_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      odd_parity <= odd_next;
      order_ok   <= order_ok_next;
      accepted   <= parity_ok && order_ok_next;
    end
  end

  `PCF_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy && !done)
  `PCF_ASSERT_NEXT(a_single_strobe, done, !done)
  `PCF_ASSERT_NOW(a_done_when_free, done, !busy)

endmodule

`default_nettype wire
